FILE: design/grid_enclosure_checker_macros.svh
// ----------------------------------------------------------------------------
// Grid enclosure checker assertion macros
// Short forms for clocked concurrent assertions, with and without reset gating.
// ----------------------------------------------------------------------------
`ifndef GRID_ENCLOSURE_CHECKER_MACROS_SVH
`define GRID_ENCLOSURE_CHECKER_MACROS_SVH

// Checked only while reset is low.
`define GEC_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("grid enclosure checker: assertion failed");

// Checked at every edge, reset cycles included.
`define GEC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("grid enclosure checker: assertion failed");

`endif

FILE: design/gec_pkg.sv
// ----------------------------------------------------------------------------
// Grid enclosure checker package
// Shared widths, register indexes, cell classes and classification helpers.
// ----------------------------------------------------------------------------
package gec_pkg;

  localparam int CELL_W         = 8;
  localparam int WIDTH_REG_W    = 9;
  localparam int HEIGHT_REG_W   = 13;
  localparam int CFG_DATA_W     = 13;
  localparam int CFG_INDEX_W    = 1;
  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 4096;

  localparam logic [CFG_INDEX_W-1:0] REG_MAP_WIDTH  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAP_HEIGHT = 1'd1;

  localparam logic [CELL_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CELL_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CELL_W-1:0] CH_N     = 8'h4E;
  localparam logic [CELL_W-1:0] CH_S     = 8'h53;
  localparam logic [CELL_W-1:0] CH_E     = 8'h45;
  localparam logic [CELL_W-1:0] CH_W     = 8'h57;

  typedef enum logic [1:0] {
    CLS_OTHER = 2'd0,
    CLS_WALK  = 2'd1,
    CLS_SPACE = 2'd2
  } cls_t;

  function automatic cls_t classify(input logic [CELL_W-1:0] b);
    cls_t c;
    case (b) inside
      CH_SPACE:                         c = CLS_SPACE;
      CH_ZERO, CH_N, CH_S, CH_E, CH_W:  c = CLS_WALK;
      default:                          c = CLS_OTHER;
    endcase
    return c;
  endfunction

  // Walkable next to space, in either order.
  function automatic logic clash(input cls_t a, input cls_t b);
    return ((a == CLS_WALK) && (b == CLS_SPACE)) || ((a == CLS_SPACE) && (b == CLS_WALK));
  endfunction

endpackage

FILE: design/gec_stream_ifs.sv
// ----------------------------------------------------------------------------
// Grid enclosure checker stream interfaces
// Valid/ready channels for map bytes in and the enclosure result out.
// ----------------------------------------------------------------------------
interface gec_cell_if;
  import gec_pkg::*;
  logic              valid;
  logic              ready;
  logic [CELL_W-1:0] cell_req;
  modport source (output valid, output cell_req, input ready);
  modport sink   (input valid, input cell_req, output ready);
endinterface

interface gec_result_if;
  logic valid;
  logic ready;
  logic enclosed;
  modport source (output valid, output enclosed, input ready);
  modport sink   (input valid, input enclosed, output ready);
endinterface

FILE: design/gec_cfg_regs.sv
// ----------------------------------------------------------------------------
// Grid enclosure checker configuration registers
// Holds the clamped last column and last row; any write restarts the grid.
// ----------------------------------------------------------------------------
module gec_cfg_regs #(
  parameter int MAX_WIDTH  = gec_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = gec_pkg::DEF_MAX_HEIGHT,
  localparam int COL_W = $clog2(MAX_WIDTH),
  localparam int ROW_W = $clog2(MAX_HEIGHT)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [gec_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [gec_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output logic [COL_W-1:0]                last_col,
  output logic [ROW_W-1:0]                last_row,
  output logic                            restart
);
  import gec_pkg::*;

  logic [WIDTH_REG_W-1:0]  wv;
  logic [HEIGHT_REG_W-1:0] hv;
  logic [COL_W-1:0]        last_col_next;
  logic [ROW_W-1:0]        last_row_next;

  assign wv = cfg_wdata[WIDTH_REG_W-1:0];
  assign hv = cfg_wdata[HEIGHT_REG_W-1:0];

  // zero reads as one, oversize saturates
  always_comb begin
    if (wv == '0) begin
      last_col_next = '0;
    end else if (32'(wv) > 32'(MAX_WIDTH)) begin
      last_col_next = COL_W'(MAX_WIDTH - 1);
    end else begin
      last_col_next = COL_W'(wv - WIDTH_REG_W'(1));
    end
    if (hv == '0) begin
      last_row_next = '0;
    end else if (32'(hv) > 32'(MAX_HEIGHT)) begin
      last_row_next = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      last_row_next = ROW_W'(hv - HEIGHT_REG_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_col <= '0;
      last_row <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MAP_WIDTH:  last_col <= last_col_next;
        REG_MAP_HEIGHT: last_row <= last_row_next;
        default: ;
      endcase
    end
  end

  assign restart = cfg_we;

endmodule

FILE: design/gec_row_buf.sv
// ----------------------------------------------------------------------------
// Grid enclosure checker row buffer
// One-row class memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module gec_row_buf #(
  parameter int DEPTH = gec_pkg::DEF_MAX_WIDTH,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  gec_pkg::cls_t     wr_cls,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output gec_pkg::cls_t     rd_cls
);
  import gec_pkg::*;

  cls_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_cls <= mem[rd_addr];
    end
  end

endmodule

FILE: design/grid_enclosure_checker.sv
// ----------------------------------------------------------------------------
// Grid enclosure checker
// One map byte per cycle while no result waits; the last cell's result is registered.
// Row buffer: one write and at most one read per cell (prefetch two columns ahead).
// Synchronous active-high reset clears position, fail flag and both valids.
// ----------------------------------------------------------------------------
module grid_enclosure_checker #(
  parameter int MAX_WIDTH  = gec_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = gec_pkg::DEF_MAX_HEIGHT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [gec_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [gec_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  gec_cell_if.sink                        cells,
  gec_result_if.source                    result
);
  import gec_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);

  // Configuration: clamped last column / last row.
  logic [COL_W-1:0] last_col;
  logic [ROW_W-1:0] last_row;
  logic             restart;

  gec_cfg_regs #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .last_col  (last_col),
    .last_row  (last_row),
    .restart   (restart)
  );

  // Input register. Refills on the same edge it drains.
  logic              s1_valid;
  logic [CELL_W-1:0] s1_byte;

  // Grid position of the cell in s1, sticky fail flag.
  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;
  logic             failed;

  // Neighbor classes. Column 0 and column 1 of the row above are kept in
  // registers (first0/first1) so a new row starts without a memory read.
  // Elsewhere "up" comes from up_reg (last cell's up-right) and "up-right"
  // from the row buffer read issued at the previous cell.
  cls_t first0, first1;
  cls_t up_reg, ul_reg, left_reg;
  cls_t rd_cls;
  cls_t cls, up, ur;

  logic first_col, last_c, first_r, last_r, is_last;
  logic fail_now, fire;
  logic [COL_W:0]   col_p2;
  logic             rd_en;

  // Result register.
  logic out_valid;
  logic out_enclosed;

  assign cls       = classify(s1_byte);
  assign first_col = (col == '0);
  assign last_c    = (col == last_col);
  assign first_r   = (row == '0);
  assign last_r    = (row == last_row);
  assign is_last   = last_c && last_r;

  assign up = first_col ? first0 : up_reg;
  assign ur = first_col ? first1 : rd_cls;

  // Each cell is checked against left, up-left, up and up-right; adjacency
  // is symmetric so the other four neighbors are covered by later cells.
  always_comb begin
    fail_now = (cls == CLS_WALK) && (first_r || last_r || first_col || last_c);
    if (!first_col && clash(cls, left_reg)) begin
      fail_now = 1'b1;
    end
    if (!first_r) begin
      if (clash(cls, up)) begin
        fail_now = 1'b1;
      end
      if (!first_col && clash(cls, ul_reg)) begin
        fail_now = 1'b1;
      end
      if (!last_c && clash(cls, ur)) begin
        fail_now = 1'b1;
      end
    end
  end

  // Only the last cell of a grid produces a result, so only it waits on
  // the result register.
  assign fire        = s1_valid && (!is_last || !out_valid || result.ready);
  assign cells.ready = !s1_valid || fire;

  // Prefetch the up-right neighbor of the next cell: column col+2.
  assign col_p2 = {1'b0, col} + (COL_W+1)'(2);
  assign rd_en  = fire && (col_p2 <= {1'b0, last_col});

  gec_row_buf #(
    .DEPTH (MAX_WIDTH)
  ) u_row_buf (
    .clk     (clk),
    .wr_en   (fire),
    .wr_addr (col),
    .wr_cls  (cls),
    .rd_en   (rd_en),
    .rd_addr (col_p2[COL_W-1:0]),
    .rd_cls  (rd_cls)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cells.ready) begin
      s1_valid <= cells.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cells.ready && cells.valid) begin
      s1_byte <= cells.cell_req;
    end
  end

  // Position and fail flag; a config write restarts the grid.
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      col    <= '0;
      row    <= '0;
      failed <= 1'b0;
    end else if (fire) begin
      if (last_c) begin
        col <= '0;
        row <= last_r ? '0 : row + ROW_W'(1);
      end else begin
        col <= col + COL_W'(1);
      end
      failed <= is_last ? 1'b0 : (failed || fail_now);
    end
  end

  // Neighbor class pipeline, payload only.
  always_ff @(posedge clk) begin
    if (fire) begin
      up_reg   <= ur;
      ul_reg   <= up;
      left_reg <= cls;
      if (first_col) begin
        first0 <= cls;
      end
      if (col == COL_W'(1)) begin
        first1 <= cls;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && is_last) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && is_last) begin
      out_enclosed <= !(failed || fail_now);
    end
  end

  assign result.valid    = out_valid;
  assign result.enclosed = out_enclosed;

endmodule

FILE: design/gec_checker.sv
// ----------------------------------------------------------------------------
// Grid enclosure checker port assertions
// Watches the top-level handshakes over time; bound to the top level.
// ----------------------------------------------------------------------------
`include "grid_enclosure_checker_macros.svh"

module gec_checker (
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_enclosed
);

  // A stalled result holds.
  `GEC_ASSERT(a_out_hold, clk, rst, (out_valid && !out_ready) |=> out_valid)
  `GEC_ASSERT(a_out_stable, clk, rst, (out_valid && !out_ready) |=> $stable(out_enclosed))

  // Input back-pressure only comes from a waiting result.
  `GEC_ASSERT(a_in_stall, clk, rst, !in_ready |-> (out_valid && !out_ready))

  // Reset empties the result register.
  `GEC_ASSERT_ALWAYS(a_rst_clear, clk, rst |=> !out_valid)

endmodule

bind grid_enclosure_checker gec_checker u_gec_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (cells.ready),
  .out_valid    (result.valid),
  .out_ready    (result.ready),
  .out_enclosed (result.enclosed)
);
